// File: rtl/skct_pkg.sv
// skct_pkg: shared types, constants and saturating arithmetic for the
// sorted keyed counter table. Depends on nothing.
`timescale 1ns / 1ps

package skct_pkg;

	// table geometry
	localparam int CAPACITY = 16;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int KEY_W    = 16;
	localparam int VAL_W    = 32;

	localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

	// request opcodes
	typedef enum logic [1:0] {
		OP_INC = 2'd0,
		OP_DEC = 2'd1,
		OP_SET = 2'd2,
		OP_GET = 2'd3
	} op_t;

	// control broadcast from the top level to every cell
	typedef struct packed {
		logic                    cap;       // request accepted: register compare
		logic                    ins;       // insert: shift up and write new entry
		logic                    upd;       // rewrite the value of the matching cell
		logic [KEY_W-1:0]        look_key;  // key of the incoming request
		logic [KEY_W-1:0]        new_key;
		logic signed [VAL_W-1:0] new_value;
	} cell_ctl_t;

	// signed add with saturation at the 32-bit limits
	function automatic logic signed [VAL_W-1:0] sat_add(
		input logic signed [VAL_W-1:0] a,
		input logic signed [VAL_W-1:0] b
	);
		logic signed [VAL_W:0] s;
		s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
		if (s[VAL_W] != s[VAL_W-1]) begin
			return s[VAL_W] ? VAL_MIN : VAL_MAX;
		end
		return s[VAL_W-1:0];
	endfunction

	// signed subtract with saturation at the 32-bit limits
	function automatic logic signed [VAL_W-1:0] sat_sub(
		input logic signed [VAL_W-1:0] a,
		input logic signed [VAL_W-1:0] b
	);
		logic signed [VAL_W:0] s;
		s = {a[VAL_W-1], a} - {b[VAL_W-1], b};
		if (s[VAL_W] != s[VAL_W-1]) begin
			return s[VAL_W] ? VAL_MIN : VAL_MAX;
		end
		return s[VAL_W-1:0];
	endfunction

endpackage

// File: rtl/skct_cell.sv
// skct_cell: one entry of the sorted table with its key compare and
// shift-up path from the lower neighbor. Depends on skct_pkg.
`timescale 1ns / 1ps

module skct_cell import skct_pkg::*; (
	input  logic                    clk,
	input  logic                    occ,        // entry lies below the fill count
	input  cell_ctl_t               ctl,
	input  logic [KEY_W-1:0]        prev_key,
	input  logic signed [VAL_W-1:0] prev_value,
	input  logic                    prev_ge,    // lower neighbor is at or above the key
	output logic [KEY_W-1:0]        key_q,
	output logic signed [VAL_W-1:0] value_q,
	output logic                    ge_s1,
	output logic                    eq_s1,
	output logic signed [VAL_W-1:0] hit_value
);

	logic ge_c;
	logic eq_c;

	// compare against the incoming key; empty slots count as above it
	assign ge_c      = !occ || (key_q >= ctl.look_key);
	assign eq_c      = occ && (key_q == ctl.look_key);
	assign hit_value = eq_c ? value_q : '0;

	// compare flags held for the update cycle
	always_ff @(posedge clk) begin
		if (ctl.cap) begin
			ge_s1 <= ge_c;
			eq_s1 <= eq_c;
		end
	end

	// entry storage: shift, insert or rewrite
	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (prev_ge) begin
				key_q   <= prev_key;
				value_q <= prev_value;
			end else if (ge_s1) begin
				key_q   <= ctl.new_key;
				value_q <= ctl.new_value;
			end
		end else if (ctl.upd && eq_s1) begin
			value_q <= ctl.new_value;
		end
	end

endmodule

// File: rtl/sorted_keyed_counter_table_top.sv
// sorted_keyed_counter_table_top: request handshake, fill count, update
// arithmetic and response register around a row of skct_cell entries.
// Depends on skct_pkg and skct_cell.
`timescale 1ns / 1ps

// The response is registered when the accepted request fires from the pending flag;
// a new request is taken only after the pending one has fired. The cell row compares
// all keys in the accept cycle and updates or shifts up when the request fires.
// The response register frees the request side while a response waits.
// Reset clears the fill count, the pending flag and the response valid;
// the entry storage has no reset and needs no clearing pass.

module sorted_keyed_counter_table_top import skct_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    req_valid,
	output logic                    req_stall,
	input  logic [1:0]              opcode,
	input  logic [KEY_W-1:0]        key,
	input  logic signed [VAL_W-1:0] amount,
	output logic                    rsp_valid,
	input  logic                    rsp_stall,
	output logic signed [VAL_W-1:0] count_value,
	output logic                    key_found,
	output logic                    table_full
);

	logic                    acc;
	logic                    fire;
	logic                    pend_q;
	logic [CNT_W-1:0]        count_q;
	op_t                     op_s1;
	logic [KEY_W-1:0]        key_s1;
	logic signed [VAL_W-1:0] amount_s1;
	logic signed [VAL_W-1:0] hit_s1;
	logic signed [VAL_W-1:0] hit_c;
	cell_ctl_t               ctl;

	logic [KEY_W-1:0]        cell_key   [CAPACITY];
	logic signed [VAL_W-1:0] cell_value [CAPACITY];
	logic signed [VAL_W-1:0] cell_hit   [CAPACITY];
	logic [CAPACITY-1:0]     cell_ge;
	logic [CAPACITY-1:0]     cell_eq;

	logic                    found;
	logic                    want_ins;
	logic                    is_full;
	logic                    do_ins;
	logic signed [VAL_W-1:0] dec_v;
	logic signed [VAL_W-1:0] new_v;
	logic signed [VAL_W-1:0] result;

	// handshake
	assign req_stall = pend_q;
	assign acc       = req_valid && !pend_q;
	assign fire      = pend_q && (!rsp_valid || !rsp_stall);

	// row of cells
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [KEY_W-1:0]        pk;
		logic signed [VAL_W-1:0] pv;
		logic                    pg;
		if (i == 0) begin : g_first
			assign pk = '0;
			assign pv = '0;
			assign pg = 1'b0;
		end else begin : g_next
			assign pk = cell_key[i-1];
			assign pv = cell_value[i-1];
			assign pg = cell_ge[i-1];
		end
		skct_cell u_cell (
			.clk        (clk),
			.occ        (CNT_W'(i) < count_q),
			.ctl        (ctl),
			.prev_key   (pk),
			.prev_value (pv),
			.prev_ge    (pg),
			.key_q      (cell_key[i]),
			.value_q    (cell_value[i]),
			.ge_s1      (cell_ge[i]),
			.eq_s1      (cell_eq[i]),
			.hit_value  (cell_hit[i])
		);
	end

	// value of the matching entry, at most one cell matches
	always_comb begin
		hit_c = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			hit_c = hit_c | cell_hit[i];
		end
	end

	// request registers for the update cycle
	always_ff @(posedge clk) begin
		if (acc) begin
			op_s1     <= op_t'(opcode);
			key_s1    <= key;
			amount_s1 <= amount;
			hit_s1    <= hit_c;
		end
	end

	// update arithmetic and insert decision
	always_comb begin
		found    = |cell_eq;
		want_ins = !found && (op_s1 == OP_INC || op_s1 == OP_SET);
		is_full  = want_ins && (count_q == CNT_W'(CAPACITY));
		do_ins   = want_ins && !is_full;
		dec_v    = sat_sub(hit_s1, amount_s1);
		unique case (op_s1)
			OP_INC:  new_v = sat_add(hit_s1, amount_s1);
			OP_DEC:  new_v = dec_v[VAL_W-1] ? '0 : dec_v;
			OP_SET:  new_v = amount_s1;
			default: new_v = hit_s1;
		endcase
		if (found) begin
			result = new_v;
		end else if (do_ins) begin
			result = amount_s1;
		end else begin
			result = '0;
		end
	end

	// broadcast to the cells
	always_comb begin
		ctl.cap       = acc;
		ctl.ins       = fire && do_ins;
		ctl.upd       = fire && found;
		ctl.look_key  = key;
		ctl.new_key   = key_s1;
		ctl.new_value = result;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q    <= 1'b0;
			count_q   <= '0;
			rsp_valid <= 1'b0;
		end else begin
			if (acc) begin
				pend_q <= 1'b1;
			end else if (fire) begin
				pend_q <= 1'b0;
			end
			if (fire && do_ins) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (fire) begin
				rsp_valid <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid <= 1'b0;
			end
		end
	end

	// response payload
	always_ff @(posedge clk) begin
		if (fire) begin
			count_value <= result;
			key_found   <= found;
			table_full  <= is_full;
		end
	end

endmodule

// File: tb/counter_table_checker.sv
// counter_table_checker: watches the request and response channels of the sorted
// keyed counter table, predicts every response and compares it field by field.
// Depends on skct_pkg.
`timescale 1ns / 1ps

module counter_table_checker import skct_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    req_valid,
	input  logic                    req_stall,
	input  logic [1:0]              opcode,
	input  logic [KEY_W-1:0]        key,
	input  logic signed [VAL_W-1:0] amount,
	input  logic                    rsp_valid,
	input  logic                    rsp_stall,
	input  logic signed [VAL_W-1:0] count_value,
	input  logic                    key_found,
	input  logic                    table_full,
	output int                      error_count,
	output int                      outstanding,
	output int                      results_seen,
	output int                      hits_seen,
	output int                      refusals_seen
);

	typedef struct packed {
		logic signed [VAL_W-1:0] value;
		logic                    found;
		logic                    full;
	} count_result_t;

	// shadow copy of the table, kept in ascending key order
	logic [KEY_W-1:0]        slot_key [CAPACITY];
	logic signed [VAL_W-1:0] slot_val [CAPACITY];
	int                      fill;
	count_result_t           awaited [$];
	int                      errors;
	int                      results;
	int                      hits;
	int                      refusals;

	// clip a wide sum to the signed 32-bit range
	function automatic logic signed [VAL_W-1:0] clamp(longint v);
		if (v > longint'(VAL_MAX)) return VAL_MAX;
		if (v < longint'(VAL_MIN)) return VAL_MIN;
		return v[VAL_W-1:0];
	endfunction

	// apply one request to the shadow table and return its response
	function automatic count_result_t predict_count(
		input op_t                     op,
		input logic [KEY_W-1:0]        k,
		input logic signed [VAL_W-1:0] a
	);
		count_result_t           r;
		int                      pos;
		int                      i;
		logic signed [VAL_W-1:0] cur;
		r = '0;
		pos = 0;
		while (pos < fill && slot_key[pos] < k) pos++;
		if (pos < fill && slot_key[pos] == k) begin
			cur = slot_val[pos];
			case (op)
				OP_INC: cur = clamp(longint'(cur) + longint'(a));
				OP_DEC: begin
					cur = clamp(longint'(cur) - longint'(a));
					if (cur < 0) cur = '0;
				end
				OP_SET: cur = a;
				default: ;
			endcase
			slot_val[pos] = cur;
			r.value = cur;
			r.found = 1'b1;
		end else if (op == OP_INC || op == OP_SET) begin
			if (fill < CAPACITY) begin
				// open a gap at the sorted position
				for (i = fill; i > pos; i--) begin
					slot_key[i] = slot_key[i-1];
					slot_val[i] = slot_val[i-1];
				end
				slot_key[pos] = k;
				slot_val[pos] = a;
				fill++;
				r.value = a;
			end else begin
				r.full = 1'b1;
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		count_result_t want;
		if (!arst_n) begin
			fill = 0;
			awaited.delete();
			errors = 0;
			results = 0;
			hits = 0;
			refusals = 0;
		end else begin
			// compare an accepted response with the oldest prediction
			if (rsp_valid && !rsp_stall) begin
				results++;
				if (awaited.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected response: value %0d found %0b full %0b",
							count_value, key_found, table_full);
				end else begin
					want = awaited.pop_front();
					if (want.found) hits++;
					if (want.full) refusals++;
					if (want.value !== count_value || want.found !== key_found ||
						want.full !== table_full) begin
						errors++;
						if (errors <= 10) begin
							$display("response %0d expected: value %0d found %0b full %0b",
								results, want.value, want.found, want.full);
							$display("response %0d actual:   value %0d found %0b full %0b",
								results, count_value, key_found, table_full);
						end
					end
				end
			end
			// predict each accepted request
			if (req_valid && !req_stall)
				awaited.insert(awaited.size(), predict_count(op_t'(opcode), key, amount));
		end
		error_count   <= errors;
		outstanding   <= awaited.size();
		results_seen  <= results;
		hits_seen     <= hits;
		refusals_seen <= refusals;
	end

endmodule

// File: tb/testbench.sv
// testbench: drives directed and random requests into the sorted keyed counter
// table with random idling on both sides and reports the verdict.
// Depends on skct_pkg, sorted_keyed_counter_table_top and counter_table_checker.
`timescale 1ns / 1ps

module testbench;
	import skct_pkg::*;

	localparam int IDLE_LIMIT   = 2000;
	localparam int RANDOM_ITEMS = 1680;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    req_valid = 1'b0;
	logic [1:0]              opcode = 2'b00;
	logic [KEY_W-1:0]        key = '0;
	logic signed [VAL_W-1:0] amount = '0;
	logic                    rsp_stall = 1'b0;
	logic                    req_stall;
	logic                    rsp_valid;
	logic signed [VAL_W-1:0] count_value;
	logic                    key_found;
	logic                    table_full;

	logic                    quiet_phase = 1'b0;
	int                      sent = 0;
	int                      stuck_cycles = 0;
	int                      error_count;
	int                      outstanding;
	int                      results_seen;
	int                      hits_seen;
	int                      refusals_seen;
	logic [KEY_W-1:0]        key_pool [$];

	sorted_keyed_counter_table_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.opcode      (opcode),
		.key         (key),
		.amount      (amount),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.count_value (count_value),
		.key_found   (key_found),
		.table_full  (table_full)
	);

	counter_table_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.opcode        (opcode),
		.key           (key),
		.amount        (amount),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.count_value   (count_value),
		.key_found     (key_found),
		.table_full    (table_full),
		.error_count   (error_count),
		.outstanding   (outstanding),
		.results_seen  (results_seen),
		.hits_seen     (hits_seen),
		.refusals_seen (refusals_seen)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// response side stalls at random outside the quiet phase
	always @(posedge clk) begin
		rsp_stall <= !quiet_phase && ($urandom_range(0, 99) < 20);
	end

	// watchdog on cycles with no accepted request or response
	always @(posedge clk) begin
		if (stuck_cycles >= IDLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			stuck_cycles <= 0;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	// present one request, with an optional idle gap first, and wait for acceptance
	task automatic send_request(
		input op_t                     op,
		input logic [KEY_W-1:0]        k,
		input logic signed [VAL_W-1:0] a
	);
		int gap;
		gap = 0;
		if (!quiet_phase && $urandom_range(0, 99) < 20) gap = $urandom_range(1, 4);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		opcode <= op;
		key <= k;
		amount <= a;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		sent++;
	endtask

	// hold off requests until every predicted response has arrived
	task automatic drain_responses();
		req_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	initial begin
		op_t                     op;
		logic [KEY_W-1:0]        k;
		logic signed [VAL_W-1:0] a;
		int                      roll;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: absent keys, key extremes, saturation and the zero floor
		send_request(OP_GET, 16'h0000, 32'sd7);
		send_request(OP_DEC, 16'h0005, 32'sd3);
		send_request(OP_INC, 16'h0000, VAL_MAX);
		send_request(OP_INC, 16'h0000, 32'sd1);
		send_request(OP_SET, 16'hFFFF, VAL_MIN);
		send_request(OP_INC, 16'hFFFF, -32'sd1);
		send_request(OP_DEC, 16'hFFFF, -32'sd5);
		send_request(OP_DEC, 16'h0000, VAL_MIN);
		send_request(OP_DEC, 16'h0000, VAL_MAX);
		send_request(OP_DEC, 16'h0000, -32'sd100);
		send_request(OP_SET, 16'h8000, 32'sd0);
		send_request(OP_INC, 16'h7FFF, 32'sh5555_AAAA);
		send_request(OP_GET, 16'h8000, VAL_MAX);
		send_request(OP_GET, 16'h0000, 32'sd0);
		send_request(OP_SET, 16'h0000, 32'sd42);
		send_request(OP_DEC, 16'h7FFF, 32'sh5555_AAAA);
		send_request(OP_GET, 16'h1234, 32'sd0);
		key_pool = '{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h1234};
		drain_responses();

		// random: mostly known keys, some fresh ones that fill the table
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			quiet_phase <= (n >= 600 && n < 900);
			if (n == 1200) drain_responses();
			op = op_t'($urandom_range(0, 3));
			roll = $urandom_range(0, 99);
			if (roll < 70) begin
				k = key_pool[$urandom_range(0, key_pool.size() - 1)];
			end else if (roll < 78) begin
				k = roll[0] ? '1 : '0;
			end else begin
				k = KEY_W'($urandom_range(0, 65535));
				if (key_pool.size() < 40) key_pool.insert(key_pool.size(), k);
			end
			roll = $urandom_range(0, 99);
			if (roll < 45) begin
				a = int'($urandom_range(0, 2000)) - 1000;
			end else if (roll < 75) begin
				a = $urandom;
			end else if (roll < 90) begin
				case ($urandom_range(0, 4))
					0: a = VAL_MAX;
					1: a = VAL_MIN;
					2: a = '0;
					3: a = -32'sd1;
					default: a = 32'sd1;
				endcase
			end else begin
				a = roll[0] ? VAL_MAX - $urandom_range(0, 500) : VAL_MIN + $urandom_range(0, 500);
			end
			send_request(op, k, a);
		end

		drain_responses();
		repeat (8) @(posedge clk);
		$display("sent %0d requests and checked %0d responses", sent, results_seen);
		$display("%0d hit a stored key, %0d inserts refused on a full table",
			hits_seen, refusals_seen);
		if (error_count == 0 && outstanding == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// File: filelist.f
rtl/skct_pkg.sv
rtl/skct_cell.sv
rtl/sorted_keyed_counter_table_top.sv
tb/counter_table_checker.sv
tb/testbench.sv
